FILE: hw/rtl/k_nearest_sorted_insert_core_defines.svh
// Assertion macros shared by the k-nearest insertion core.
`ifndef K_NEAREST_SORTED_INSERT_CORE_DEFINES_SVH
`define K_NEAREST_SORTED_INSERT_CORE_DEFINES_SVH

`ifndef SYNTH
`define KNSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("knsi assertion failed");
`define KNSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knsi assertion failed");
`else
`define KNSI_ASSERT_IMP(lbl, ante, cons)
`define KNSI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/knsi_pkg.sv
package knsi_pkg;

  localparam int LIST_DEPTH    = 8;
  localparam int INDEX_BITS    = 16;
  localparam int DISTANCE_BITS = 32;
  localparam int SLOT_BITS     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int POS_BITS      = 6;

  typedef enum logic [1:0] {
    REQ_OFFER = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef struct packed {
    req_t                     op;
    logic [INDEX_BITS-1:0]    index;
    logic [DISTANCE_BITS-1:0] distance;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

FILE: hw/rtl/knsi_front.sv
module knsi_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            req_type,
  input  logic [knsi_pkg::INDEX_BITS-1:0]       particle_index,
  input  logic [knsi_pkg::DISTANCE_BITS-1:0]    distance_sq,
  input  logic                                  q_pop,
  output logic                                  q_valid,
  output knsi_pkg::cmd_t                        q_cmd
);

  knsi_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           known;
  logic           push;
  logic           full;

  // Unused request codes are taken and dropped without reaching the queue.
  assign known = (req_type == knsi_pkg::REQ_OFFER) || (req_type == knsi_pkg::REQ_CLEAR) ||
                 (req_type == knsi_pkg::REQ_READ);
  assign full      = (count == 2'd2);
  assign req_stall = full;
  assign push      = req_valid && !full && known;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{op: knsi_pkg::req_t'(req_type), index: particle_index,
                         distance: distance_sq};
    end
  end

endmodule

FILE: hw/rtl/knsi_back.sv
`include "k_nearest_sorted_insert_core_defines.svh"

module knsi_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  knsi_pkg::cmd_t                        q_cmd,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic                                  accepted,
  output logic [knsi_pkg::POS_BITS-1:0]         position,
  output logic [knsi_pkg::INDEX_BITS-1:0]       entry_index,
  output logic [knsi_pkg::DISTANCE_BITS-1:0]    entry_distance,
  output logic                                  entry_valid,
  output logic                                  last
);

  localparam int D = knsi_pkg::LIST_DEPTH;
  localparam logic [knsi_pkg::SLOT_BITS-1:0] LAST_SLOT = knsi_pkg::SLOT_BITS'(D - 1);
  localparam logic [knsi_pkg::POS_BITS-1:0]  LAST_POS  = knsi_pkg::POS_BITS'(D - 1);

  logic [knsi_pkg::INDEX_BITS-1:0]    slot_nb   [D];
  logic [knsi_pkg::DISTANCE_BITS-1:0] slot_dist [D];
  logic [D-1:0]                       slot_valid;

  knsi_pkg::back_state_t              state;
  knsi_pkg::back_state_t              state_next;
  logic [knsi_pkg::SLOT_BITS-1:0]     rd_slot;
  logic [knsi_pkg::SLOT_BITS-1:0]     rd_slot_next;

  logic                               load_ok;
  logic                               emit;
  logic                               do_insert;
  logic                               do_clear;
  logic                               reject;
  logic [D-1:0]                       ge;
  logic [D-1:0]                       first;
  logic [knsi_pkg::SLOT_BITS-1:0]     ins_pos;
  logic [D-1:0]                       sorted_ok;

  logic                               accepted_next;
  logic [knsi_pkg::POS_BITS-1:0]      position_next;
  logic [knsi_pkg::INDEX_BITS-1:0]    entry_index_next;
  logic [knsi_pkg::DISTANCE_BITS-1:0] entry_distance_next;
  logic                               entry_valid_next;
  logic                               last_next;

  assign load_ok = !rsp_valid || !rsp_stall;

  // Each cell compares its entry with the candidate. An entry stays put when it is
  // valid and not farther; the first cell that fails takes the candidate and every
  // cell behind it takes its neighbor's entry. The last cell never keeps its entry.
  always_comb begin
    ge      = '0;
    first   = '0;
    ins_pos = '0;
    for (int j = 0; j < D; j++) begin
      if (j < D - 1) begin
        ge[j] = slot_valid[j] && (slot_dist[j] <= q_cmd.distance);
      end
    end
    for (int j = 0; j < D; j++) begin
      if (j == 0) begin
        first[j] = !ge[j];
      end else begin
        first[j] = !ge[j] && ge[j-1];
      end
      if (first[j]) begin
        ins_pos = ins_pos | knsi_pkg::SLOT_BITS'(j);
      end
    end
  end

  assign reject = slot_valid[D-1] && (slot_dist[D-1] < q_cmd.distance);

  always_comb begin
    state_next = state;
    unique case (state)
      knsi_pkg::BK_IDLE: begin
        if (q_pop && q_cmd.op == knsi_pkg::REQ_READ) begin
          state_next = knsi_pkg::BK_READ;
        end
      end
      knsi_pkg::BK_READ: begin
        if (load_ok && rd_slot == LAST_SLOT) begin
          state_next = knsi_pkg::BK_IDLE;
        end
      end
      default: state_next = knsi_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop               = 1'b0;
    emit                = 1'b0;
    do_insert           = 1'b0;
    do_clear            = 1'b0;
    rd_slot_next        = rd_slot;
    accepted_next       = 1'b0;
    position_next       = '0;
    entry_index_next    = '0;
    entry_distance_next = '0;
    entry_valid_next    = 1'b0;
    last_next           = 1'b1;
    unique case (state)
      knsi_pkg::BK_IDLE: begin
        q_pop = q_valid && load_ok;
        if (q_pop) begin
          unique case (q_cmd.op)
            knsi_pkg::REQ_OFFER: begin
              emit          = 1'b1;
              do_insert     = !reject;
              accepted_next = !reject;
              position_next = reject ? '0 : knsi_pkg::POS_BITS'(ins_pos);
            end
            knsi_pkg::REQ_CLEAR: begin
              emit     = 1'b1;
              do_clear = 1'b1;
            end
            knsi_pkg::REQ_READ: begin
              rd_slot_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      knsi_pkg::BK_READ: begin
        emit                = load_ok;
        position_next       = knsi_pkg::POS_BITS'(rd_slot);
        entry_index_next    = slot_nb[rd_slot];
        entry_distance_next = slot_dist[rd_slot];
        entry_valid_next    = slot_valid[rd_slot];
        last_next           = (rd_slot == LAST_SLOT);
        if (load_ok) begin
          rd_slot_next = (rd_slot == LAST_SLOT) ? '0 : rd_slot + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= knsi_pkg::BK_IDLE;
      rd_slot   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_slot <= rd_slot_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      accepted       <= accepted_next;
      position       <= position_next;
      entry_index    <= entry_index_next;
      entry_distance <= entry_distance_next;
      entry_valid    <= entry_valid_next;
      last           <= last_next;
    end
  end

  // Empty slots always hold the cleared contents, so shifting them keeps that true.
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int j = 0; j < D; j++) begin
        slot_nb[j]   <= '0;
        slot_dist[j] <= '1;
      end
      slot_valid <= '0;
    end else if (do_insert) begin
      for (int j = 0; j < D; j++) begin
        if (ge[j]) begin
          slot_nb[j]    <= slot_nb[j];
          slot_dist[j]  <= slot_dist[j];
          slot_valid[j] <= slot_valid[j];
        end else if (first[j]) begin
          slot_nb[j]    <= q_cmd.index;
          slot_dist[j]  <= q_cmd.distance;
          slot_valid[j] <= 1'b1;
        end else if (j > 0) begin
          slot_nb[j]    <= slot_nb[j-1];
          slot_dist[j]  <= slot_dist[j-1];
          slot_valid[j] <= slot_valid[j-1];
        end
      end
    end
  end

  always_comb begin
    sorted_ok = '1;
    for (int j = 0; j + 1 < D; j++) begin
      sorted_ok[j] = !slot_valid[j+1] || (slot_dist[j] <= slot_dist[j+1]);
    end
  end

  `KNSI_ASSERT_IMP(a_valid_prefix, 1'b1, ((slot_valid >> 1) & ~slot_valid) == '0)
  `KNSI_ASSERT_IMP(a_list_sorted, 1'b1, sorted_ok == '1)
  `KNSI_ASSERT_IMP(a_no_pop_in_read, state == knsi_pkg::BK_READ, !q_pop)
  `KNSI_ASSERT_NXT(a_read_last, state == knsi_pkg::BK_READ && load_ok, last == (position == LAST_POS))

endmodule

FILE: hw/rtl/k_nearest_sorted_insert_core.sv
// Sorted list of the nearest neighbors, kept by insertion.
// Request channel: req_valid / req_stall with req_type, particle_index and
// distance_sq. Type offer inserts a candidate, clear empties the list, read
// dumps every slot; the unused code is taken and dropped without a response.
// Response channel: rsp_valid / rsp_stall with accepted, position, entry_index,
// entry_distance, entry_valid and last. Offer and clear give one response each;
// read gives one response per slot, slot 0 first, with last on the final slot.
// Requests enter a two-entry queue, so the request side keeps moving while the
// list engine waits on the response side.
// A request passes through the queue and then the response register before its
// response shows on rsp_valid; it can be taken while rsp_stall is low.
// Throughput: one offer or clear per cycle while rsp_stall stays low; a read
// holds the list engine while it sends each slot through the single response register.
// While rsp_stall is high the response register holds, the engine stops and the
// queue fills, after which req_stall rises.
// Synchronous reset empties the queue and the list; no response is pending.
module k_nearest_sorted_insert_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            req_type,
  input  logic [knsi_pkg::INDEX_BITS-1:0]       particle_index,
  input  logic [knsi_pkg::DISTANCE_BITS-1:0]    distance_sq,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic                                  accepted,
  output logic [knsi_pkg::POS_BITS-1:0]         position,
  output logic [knsi_pkg::INDEX_BITS-1:0]       entry_index,
  output logic [knsi_pkg::DISTANCE_BITS-1:0]    entry_distance,
  output logic                                  entry_valid,
  output logic                                  last
);

  knsi_pkg::cmd_t        q_cmd;
  logic                  q_valid;
  logic                  q_pop;

  knsi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .particle_index (particle_index),
    .distance_sq    (distance_sq),
    .q_pop          (q_pop),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd)
  );

  knsi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_cmd          (q_cmd),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .accepted       (accepted),
    .position       (position),
    .entry_index    (entry_index),
    .entry_distance (entry_distance),
    .entry_valid    (entry_valid),
    .last           (last)
  );

endmodule

FILE: tb/sv/knsi_neighbor_checker.sv
`timescale 1ns / 1ps

module knsi_neighbor_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  input  logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic [knsi_pkg::INDEX_BITS-1:0]    particle_index,
  input  logic [knsi_pkg::DISTANCE_BITS-1:0] distance_sq,
  input  logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  logic                               accepted,
  input  logic [knsi_pkg::POS_BITS-1:0]      position,
  input  logic [knsi_pkg::INDEX_BITS-1:0]    entry_index,
  input  logic [knsi_pkg::DISTANCE_BITS-1:0] entry_distance,
  input  logic                               entry_valid,
  input  logic                               last,
  output int                                 mismatches,
  output int                                 outstanding
);

  typedef struct packed {
    logic                               acc;
    logic [knsi_pkg::POS_BITS-1:0]      pos;
    logic [knsi_pkg::INDEX_BITS-1:0]    idx;
    logic [knsi_pkg::DISTANCE_BITS-1:0] dsq;
    logic                               vld;
    logic                               fin;
  } neighbor_rsp_t;

  logic [knsi_pkg::INDEX_BITS-1:0]    near_idx  [knsi_pkg::LIST_DEPTH];
  logic [knsi_pkg::DISTANCE_BITS-1:0] near_dist [knsi_pkg::LIST_DEPTH];
  logic                               near_vld  [knsi_pkg::LIST_DEPTH];

  neighbor_rsp_t expected_rsp_q[$];
  int            fault_count = 0;

  task automatic empty_neighbors();
    for (int s = 0; s < knsi_pkg::LIST_DEPTH; s++) begin
      near_idx[s]  = '0;
      near_dist[s] = '1;
      near_vld[s]  = 1'b0;
    end
  endtask

  task automatic push_rsp(logic acc, int pos, logic [knsi_pkg::INDEX_BITS-1:0] idx,
                          logic [knsi_pkg::DISTANCE_BITS-1:0] dsq, logic vld, logic fin);
    neighbor_rsp_t r;
    r.acc = acc;
    r.pos = knsi_pkg::POS_BITS'(pos);
    r.idx = idx;
    r.dsq = dsq;
    r.vld = vld;
    r.fin = fin;
    expected_rsp_q.push_back(r);
  endtask

  // Insert the candidate at the tail and bubble it forward past empty or
  // strictly farther entries, so equal distances keep their arrival order.
  task automatic insert_neighbor(logic [knsi_pkg::INDEX_BITS-1:0] idx,
                                 logic [knsi_pkg::DISTANCE_BITS-1:0] dsq);
    int                                 slot;
    logic [knsi_pkg::INDEX_BITS-1:0]    t_idx;
    logic [knsi_pkg::DISTANCE_BITS-1:0] t_dist;
    logic                               t_vld;
    slot = knsi_pkg::LIST_DEPTH - 1;
    if (near_vld[slot] && near_dist[slot] < dsq) begin
      push_rsp(1'b0, 0, '0, '0, 1'b0, 1'b1);
    end else begin
      near_idx[slot]  = idx;
      near_dist[slot] = dsq;
      near_vld[slot]  = 1'b1;
      while (slot > 0 && (!near_vld[slot-1] || dsq < near_dist[slot-1])) begin
        t_idx  = near_idx[slot-1];
        t_dist = near_dist[slot-1];
        t_vld  = near_vld[slot-1];
        near_idx[slot-1]  = near_idx[slot];
        near_dist[slot-1] = near_dist[slot];
        near_vld[slot-1]  = near_vld[slot];
        near_idx[slot]  = t_idx;
        near_dist[slot] = t_dist;
        near_vld[slot]  = t_vld;
        slot--;
      end
      push_rsp(1'b1, slot, '0, '0, 1'b0, 1'b1);
    end
  endtask

  task automatic predict_request(logic [1:0] kind, logic [knsi_pkg::INDEX_BITS-1:0] idx,
                                 logic [knsi_pkg::DISTANCE_BITS-1:0] dsq);
    case (kind)
      knsi_pkg::REQ_OFFER: begin
        insert_neighbor(idx, dsq);
      end
      knsi_pkg::REQ_CLEAR: begin
        empty_neighbors();
        push_rsp(1'b0, 0, '0, '0, 1'b0, 1'b1);
      end
      knsi_pkg::REQ_READ: begin
        for (int s = 0; s < knsi_pkg::LIST_DEPTH; s++)
          push_rsp(1'b0, s, near_idx[s], near_dist[s], near_vld[s],
                   s == knsi_pkg::LIST_DEPTH - 1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    neighbor_rsp_t want;
    if (rst) begin
      empty_neighbors();
      expected_rsp_q.delete();
    end else begin
      if (req_valid && !req_stall)
        predict_request(req_type, particle_index, distance_sq);
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response arrived with no request waiting for it");
          fault_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          compare_field("accepted", 64'(want.acc), 64'(accepted));
          compare_field("position", 64'(want.pos), 64'(position));
          compare_field("entry_index", 64'(want.idx), 64'(entry_index));
          compare_field("entry_distance", 64'(want.dsq), 64'(entry_distance));
          compare_field("entry_valid", 64'(want.vld), 64'(entry_valid));
          compare_field("last", 64'(want.fin), 64'(last));
        end
      end
    end
    mismatches  <= fault_count;
    outstanding <= expected_rsp_q.size();
  end

endmodule

FILE: tb/sv/k_nearest_sorted_insert_core_test.sv
`timescale 1ns / 1ps

module k_nearest_sorted_insert_core_test;

  // The fourth request code is taken by the block and dropped.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 150;
  localparam int         DRAIN_LIMIT = 5000;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               req_valid;
  logic                               req_stall;
  logic [1:0]                         req_type;
  logic [knsi_pkg::INDEX_BITS-1:0]    particle_index;
  logic [knsi_pkg::DISTANCE_BITS-1:0] distance_sq;
  logic                               rsp_valid;
  logic                               rsp_stall;
  logic                               accepted;
  logic [knsi_pkg::POS_BITS-1:0]      position;
  logic [knsi_pkg::INDEX_BITS-1:0]    entry_index;
  logic [knsi_pkg::DISTANCE_BITS-1:0] entry_distance;
  logic                               entry_valid;
  logic                               last;
  int                                 mismatches;
  int                                 outstanding;

  // Shared between the request and response processes.
  bit quiet;
  bit hold_rsp;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  k_nearest_sorted_insert_core dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .particle_index (particle_index),
    .distance_sq    (distance_sq),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .accepted       (accepted),
    .position       (position),
    .entry_index    (entry_index),
    .entry_distance (entry_distance),
    .entry_valid    (entry_valid),
    .last           (last)
  );

  knsi_neighbor_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .particle_index (particle_index),
    .distance_sq    (distance_sq),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .accepted       (accepted),
    .position       (position),
    .entry_index    (entry_index),
    .entry_distance (entry_distance),
    .entry_valid    (entry_valid),
    .last           (last),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 10)
      return 0;
    if (r < 18)
      return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Small ranges give many ties, wide ones exercise every bit.
  function automatic logic [knsi_pkg::DISTANCE_BITS-1:0] pick_distance(int mode);
    case (mode)
      0: return $urandom_range(0, 7);
      1: return $urandom();
      2: return '1 - $urandom_range(0, 3);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [knsi_pkg::INDEX_BITS-1:0] rand_index();
    return knsi_pkg::INDEX_BITS'($urandom());
  endfunction

  function automatic logic [knsi_pkg::DISTANCE_BITS-1:0] rand_distance();
    return knsi_pkg::DISTANCE_BITS'($urandom());
  endfunction

  task automatic send_request(logic [1:0] kind, logic [knsi_pkg::INDEX_BITS-1:0] idx,
                              logic [knsi_pkg::DISTANCE_BITS-1:0] dsq);
    int gap;
    @(negedge clk);
    req_valid      <= 1'b1;
    req_type       <= kind;
    particle_index <= idx;
    distance_sq    <= dsq;
    do @(posedge clk); while (req_stall);
    gap = idle_length();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Response side: random stall runs, plus one long hold that lets the
  // request queue fill up while requests keep coming.
  initial begin
    bit held;
    bit level;
    int span;
    held = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      if (hold_rsp && !held) begin
        held  = 1'b1;
        level = 1'b1;
        span  = 60;
      end else if (quiet) begin
        level = 1'b0;
        span  = 1;
      end else begin
        level = ($urandom_range(0, 9) < 3);
        if (!level)
          span = $urandom_range(1, 6);
        else if ($urandom_range(0, 9) == 0)
          span = $urandom_range(10, 30);
        else
          span = $urandom_range(1, 3);
      end
      @(negedge clk);
      rsp_stall <= level;
      repeat (span - 1) @(negedge clk);
    end
  end

  initial begin
    int sent;
    int choice;
    int count;
    int mode;
    int waited;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req_type       = knsi_pkg::REQ_OFFER;
    particle_index = '0;
    distance_sq    = '0;
    quiet          = 1'b0;
    hold_rsp       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Read an empty list, then fill it with extremes and ties.
    send_request(knsi_pkg::REQ_READ, '0, '0);
    send_request(knsi_pkg::REQ_OFFER, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(knsi_pkg::REQ_OFFER, 16'h0000, 32'h0000_0000);
    send_request(knsi_pkg::REQ_OFFER, 16'h1234, 32'h0000_0000);
    send_request(REQ_UNUSED, 16'hABCD, 32'h0000_0001);
    send_request(knsi_pkg::REQ_OFFER, 16'h0100, 32'd100);
    send_request(knsi_pkg::REQ_OFFER, 16'h0050, 32'd50);
    send_request(knsi_pkg::REQ_OFFER, 16'h0200, 32'd200);
    send_request(knsi_pkg::REQ_OFFER, 16'h7FFE, 32'hFFFF_FFFE);
    send_request(knsi_pkg::REQ_OFFER, 16'h0075, 32'd75);
    // The list is full now; an equal tail distance is still taken in.
    send_request(knsi_pkg::REQ_OFFER, 16'h5555, 32'hFFFF_FFFF);
    send_request(knsi_pkg::REQ_OFFER, 16'h0300, 32'd300);
    send_request(knsi_pkg::REQ_OFFER, 16'hAAAA, 32'hFFFF_FFFF);
    send_request(knsi_pkg::REQ_READ, '0, '0);
    send_request(knsi_pkg::REQ_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(knsi_pkg::REQ_READ, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(knsi_pkg::REQ_OFFER, 16'h0000, 32'h0000_0000);
    send_request(knsi_pkg::REQ_READ, '0, '0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 40 && !hold_rsp)
        hold_rsp = 1'b1;
      quiet = (sent >= 100 && sent < 130);
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        send_request(knsi_pkg::REQ_CLEAR, rand_index(), rand_distance());
        count = $urandom_range(1, 12);
        mode  = $urandom_range(0, 3);
        repeat (count)
          send_request(knsi_pkg::REQ_OFFER, rand_index(), pick_distance(mode));
        send_request(knsi_pkg::REQ_READ, rand_index(), rand_distance());
        sent += count + 2;
      end else if (choice == 7) begin
        send_request(knsi_pkg::REQ_READ, rand_index(), rand_distance());
        sent++;
      end else if (choice == 8) begin
        send_request(REQ_UNUSED, rand_index(), rand_distance());
        send_request(knsi_pkg::REQ_OFFER, rand_index(), rand_distance());
        sent += 2;
      end else begin
        send_request(knsi_pkg::REQ_OFFER, rand_index(),
                     pick_distance($urandom_range(0, 3)));
        sent++;
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    req_valid <= 1'b0;

    waited = 0;
    @(negedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (knsi_pkg::LIST_DEPTH + 8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/knsi_pkg.sv
hw/rtl/knsi_front.sv
hw/rtl/knsi_back.sv
hw/rtl/k_nearest_sorted_insert_core.sv
tb/sv/knsi_neighbor_checker.sv
tb/sv/k_nearest_sorted_insert_core_test.sv
